// ----- hw/rtl/rqt_pkg.sv -----
package rqt_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PEER_COUNT_DEF  = 8;

    localparam int KEY_W    = 64;
    localparam int IDX_W    = 64;
    localparam int PEER_W   = 3;
    localparam int QS_W     = 4;
    localparam int STATUS_W = 2;

    localparam int PAYLOAD_W = KEY_W + IDX_W + PEER_W;
    localparam int DATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W     = DATA_W - PAYLOAD_W;

    localparam logic [QS_W-1:0] QS_RESET = 4'd2;

    typedef enum logic
    {
        FUNC_ADD     = 1'b0,
        FUNC_CONFIRM = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_RELEASED   = 2'd0,
        STATUS_BACKWARD   = 2'd1,
        STATUS_FULL       = 2'd2,
        STATUS_UNEXPECTED = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_REL
    } state_t;

    typedef struct packed
    {
        logic shift;
        logic load;
        logic mark;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/rqt_cell.sv -----
module rqt_cell
    import rqt_pkg::*;
#(
    parameter int PEER_COUNT = PEER_COUNT_DEF
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [KEY_W-1:0]      nb_key,
    input  logic [IDX_W-1:0]      nb_index,
    input  logic [PEER_W-1:0]     nb_req,
    input  logic [PEER_COUNT-1:0] nb_mask,
    input  logic [KEY_W-1:0]      new_key,
    input  logic [IDX_W-1:0]      new_index,
    input  logic [PEER_W-1:0]     new_req,
    input  logic [PEER_COUNT-1:0] mark_bit,
    input  logic [KEY_W-1:0]      cmp_key,
    output logic [KEY_W-1:0]      key,
    output logic [IDX_W-1:0]      index,
    output logic [PEER_W-1:0]     req,
    output logic [PEER_COUNT-1:0] mask,
    output logic                  hit
);

    logic [KEY_W-1:0]      key_reg;
    logic [IDX_W-1:0]      index_reg;
    logic [PEER_W-1:0]     req_reg;
    logic [PEER_COUNT-1:0] mask_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg   <= nb_key;
            index_reg <= nb_index;
            req_reg   <= nb_req;
            mask_reg  <= nb_mask;
        end
        else if (ctl.load)
        begin
            key_reg   <= new_key;
            index_reg <= new_index;
            req_reg   <= new_req;
            mask_reg  <= '0;
        end
        else if (ctl.mark)
        begin
            mask_reg <= mask_reg | mark_bit;
        end
    end

    assign key   = key_reg;
    assign index = index_reg;
    assign req   = req_reg;
    assign mask  = mask_reg;
    assign hit   = (key_reg == cmp_key);

endmodule

// ----- hw/rtl/read_index_quorum_tracker_core.sv -----
// Pending read-index queue with peer quorum tracking.
// Input words arrive on s_axis: tuser selects add (0) or peer confirm (1), and
// tdata carries the context key, read index and peer slot. Result words leave on
// m_axis with the key, index and requester in tdata, the status in tuser and
// tlast on the final result caused by one input word.
// The quorum size register is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Each input word is accepted in S_IDLE, its key is compared against every
// queued entry in parallel in S_MATCH, and S_EXEC decides and updates the
// entry. A confirm that reaches quorum then walks S_REL, emitting the head cell
// and shifting the row by one for every released entry. A rejected add is
// registered on m_axis from S_EXEC, and the released words of a confirm from S_REL.
// Reset empties the queue and sets the quorum size to two.
// When the receiver stalls, the output register holds its word and the
// release walk pauses until the word is taken; no input is accepted meanwhile.
module read_index_quorum_tracker_core
    import rqt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PEER_COUNT  = PEER_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0: ctx_key, commit index, peer_id, zero padding.
    input  logic [DATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: func.
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0: out_key, out_index, out_requester, zero padding.
    output logic [DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status.
    output logic [STATUS_W-1:0] m_axis_tuser,
    output logic              m_axis_tlast,
    input  logic              cfg_we,
    input  logic [QS_W-1:0]   cfg_wdata
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int PC_W  = $clog2(PEER_COUNT + 2);
    localparam int CMP_W = (PC_W > QS_W) ? PC_W : QS_W;

    state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0] cut_reg, cut_next;
    logic [QS_W-1:0] qs_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PEER_W-1:0] peer_reg;
    func_t             func_reg;
    logic              hit_any_reg;
    logic [PW-1:0]     hit_pos_reg;

    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;
    logic [PEER_W-1:0]   out_req_reg, out_req_next;
    status_t             out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic [KEY_W-1:0]      c_key   [QUEUE_DEPTH];
    logic [IDX_W-1:0]      c_index [QUEUE_DEPTH];
    logic [PEER_W-1:0]     c_req   [QUEUE_DEPTH];
    logic [PEER_COUNT-1:0] c_mask  [QUEUE_DEPTH];
    cell_ctl_t             c_ctl   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] c_hit;
    logic [QUEUE_DEPTH-1:0] live;
    logic [QUEUE_DEPTH-1:0] hit_vec;

    logic                  out_free;
    logic                  shift_all;
    logic                  load_en;
    logic                  mark_en;
    logic [PEER_COUNT-1:0] mark_bit;
    logic [PEER_COUNT-1:0] new_mask;
    logic [CMP_W-1:0]      pop;
    logic                  quorum_met;
    logic                  hit_any;
    logic [PW-1:0]         hit_pos;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_req_reg, out_index_reg, out_key_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    assign mark_bit = (32'(peer_reg) < PEER_COUNT) ? (PEER_COUNT'(1) << peer_reg) : '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0]      nb_key;
        logic [IDX_W-1:0]      nb_index;
        logic [PEER_W-1:0]     nb_req;
        logic [PEER_COUNT-1:0] nb_mask;

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign nb_key   = '0;
            assign nb_index = '0;
            assign nb_req   = '0;
            assign nb_mask  = '0;
        end
        else
        begin : g_body
            assign nb_key   = c_key[i+1];
            assign nb_index = c_index[i+1];
            assign nb_req   = c_req[i+1];
            assign nb_mask  = c_mask[i+1];
        end

        assign c_ctl[i].shift = shift_all;
        assign c_ctl[i].load  = load_en && (cnt_reg[PW-1:0] == PW'(i));
        assign c_ctl[i].mark  = mark_en && (hit_pos_reg == PW'(i));
        assign live[i]        = (CW'(i) < cnt_reg);
        assign hit_vec[i]     = c_hit[i] && live[i];

        rqt_cell #(
            .PEER_COUNT (PEER_COUNT)
        ) u_cell (
            .clk       (clk),
            .ctl       (c_ctl[i]),
            .nb_key    (nb_key),
            .nb_index  (nb_index),
            .nb_req    (nb_req),
            .nb_mask   (nb_mask),
            .new_key   (key_reg),
            .new_index (idx_reg),
            .new_req   (peer_reg),
            .mark_bit  (mark_bit),
            .cmp_key   (key_reg),
            .key       (c_key[i]),
            .index     (c_index[i]),
            .req       (c_req[i]),
            .mask      (c_mask[i]),
            .hit       (c_hit[i])
        );
    end

    always_comb
    begin
        hit_any = |hit_vec;
        hit_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_pos = PW'(i);
            end
        end
    end

    always_comb
    begin
        new_mask = c_mask[hit_pos_reg] | mark_bit;
        pop      = '0;
        for (int b = 0; b < PEER_COUNT; b++)
        begin
            pop = pop + CMP_W'(new_mask[b]);
        end
        quorum_met = ((pop + CMP_W'(1)) >= CMP_W'(qs_reg));
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        cut_next        = cut_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_key_next    = out_key_reg;
        out_index_next  = out_index_reg;
        out_req_next    = out_req_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        shift_all       = 1'b0;
        load_en         = 1'b0;
        mark_en         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (func_reg == FUNC_ADD)
                    begin
                        if (!hit_any_reg)
                        begin
                            if ((cnt_reg != '0) && (idx_reg < c_index[0]))
                            begin
                                out_valid_next  = 1'b1;
                                out_key_next    = key_reg;
                                out_index_next  = idx_reg;
                                out_req_next    = peer_reg;
                                out_status_next = STATUS_BACKWARD;
                                out_last_next   = 1'b1;
                            end
                            else if (cnt_reg == CW'(QUEUE_DEPTH))
                            begin
                                out_valid_next  = 1'b1;
                                out_key_next    = key_reg;
                                out_index_next  = idx_reg;
                                out_req_next    = peer_reg;
                                out_status_next = STATUS_FULL;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                load_en  = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                    end
                    else if (hit_any_reg)
                    begin
                        mark_en = 1'b1;
                        if (quorum_met)
                        begin
                            cut_next   = c_index[hit_pos_reg];
                            rem_next   = hit_pos_reg;
                            state_next = S_REL;
                        end
                    end
                end
            end
            S_REL:
            begin
                if (out_free)
                begin
                    shift_all      = 1'b1;
                    cnt_next       = cnt_reg - CW'(1);
                    out_valid_next = 1'b1;
                    out_key_next   = c_key[0];
                    out_index_next = cut_reg;
                    out_req_next   = c_req[0];
                    if (c_index[0] > cut_reg)
                    begin
                        out_status_next = STATUS_UNEXPECTED;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        out_status_next = STATUS_RELEASED;
                        out_last_next   = (rem_reg == '0);
                        if (rem_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rem_next = rem_reg - PW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            qs_reg        <= QS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                qs_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg        <= cut_next;
        out_key_reg    <= out_key_next;
        out_index_reg  <= out_index_next;
        out_req_reg    <= out_req_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            idx_reg  <= s_axis_tdata[KEY_W+IDX_W-1:KEY_W];
            peer_reg <= s_axis_tdata[PAYLOAD_W-1:KEY_W+IDX_W];
            func_reg <= func_t'(s_axis_tuser[0]);
        end
        if (state_reg == S_MATCH)
        begin
            hit_any_reg <= hit_any;
            hit_pos_reg <= hit_pos;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |-> $onehot0(hit_vec))
        else $error("key matches more than one live entry");

    a_release_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL) |-> (CW'(rem_reg) < cnt_reg))
        else $error("release walk runs past the queued entries");

    a_add_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg != S_REL) || $past(func_reg == FUNC_CONFIRM))
        else $error("release started by an add word");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rqt_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed
    {
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  index;
        logic [PEER_W-1:0] requester;
        status_t           status;
        logic              last;
    } read_result_t;

    typedef enum
    {
        ROW_NONE,
        ROW_ECHO,
        ROW_PREDICT
    } row_kind_t;

    typedef struct
    {
        func_t             func;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  index;
        logic [PEER_W-1:0] peer;
        row_kind_t         kind;
        status_t           status;
        int                repeats;
    } request_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata;
    logic [0:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;
    logic                cfg_we;
    logic [QS_W-1:0]     cfg_wdata;

    // Shadow copy of the pending read queue.
    logic [KEY_W-1:0]          q_key [DEPTH];
    logic [IDX_W-1:0]          q_index [DEPTH];
    logic [PEER_W-1:0]         q_requester [DEPTH];
    logic [PEER_COUNT_DEF-1:0] q_mask [DEPTH];
    int                        q_head;
    int                        q_count;
    logic [QS_W-1:0]           quorum;

    read_result_t word_results[$];
    read_result_t awaited_results[$];
    int           errors = 0;
    int           words_taken = 0;
    logic [KEY_W-1:0]  focus_key = '0;
    logic [PEER_W-1:0] peer_turn = '0;

    // The queue is filled to its depth by the repeated add, then the last key releases all.
    request_row_t request_rows [15] = '{
        '{FUNC_CONFIRM, 64'd5,     64'd0,   3'd0, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_ADD,     64'd0,     64'd0,   3'd0, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_ADD,     64'd0,     64'd100, 3'd3, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_ADD,     '1,        '1,      3'd7, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_ADD,     64'd3,     64'd0,   3'd5, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_CONFIRM, 64'd3,     '1,      3'd1, ROW_PREDICT, STATUS_RELEASED, 1},
        '{FUNC_ADD,     64'h10,    64'd50,  3'd2, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_CONFIRM, 64'd3,     64'd0,   3'd7, ROW_PREDICT, STATUS_RELEASED, 1},
        '{FUNC_ADD,     64'h11,    64'd49,  3'd4, ROW_ECHO,    STATUS_BACKWARD, 1},
        '{FUNC_ADD,     64'h12,    64'd0,   3'd6, ROW_ECHO,    STATUS_BACKWARD, 1},
        '{FUNC_ADD,     64'h100,   64'd51,  3'd1, ROW_NONE,    STATUS_RELEASED, 15},
        '{FUNC_ADD,     64'h200,   64'd70,  3'd3, ROW_ECHO,    STATUS_FULL,     1},
        '{FUNC_ADD,     64'h201,   64'd1,   3'd0, ROW_ECHO,    STATUS_BACKWARD, 1},
        '{FUNC_ADD,     64'h100,   64'd5,   3'd2, ROW_NONE,    STATUS_RELEASED, 1},
        '{FUNC_CONFIRM, 64'h10E,   64'd0,   3'd0, ROW_PREDICT, STATUS_RELEASED, 1}
    };

    logic [QS_W-1:0] phase_quorum [7] = '{4'd1, 4'd9, 4'd0, 4'd3, 4'd15, 4'd5, 4'd2};
    int              phase_items [7]  = '{12, 24, 12, 12, 12, 12, 12};

    read_index_quorum_tracker_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int find_pending(logic [KEY_W-1:0] k);
        for (int p = 0; p < q_count; p++)
        begin
            if (q_key[(q_head + p) % DEPTH] == k)
            begin
                return p;
            end
        end
        return q_count;
    endfunction

    function automatic void predict_tracker(func_t f, logic [KEY_W-1:0] k,
                                            logic [IDX_W-1:0] x, logic [PEER_W-1:0] p);
        int               pos;
        int               s;
        int               h;
        logic [IDX_W-1:0] cut_index;
        word_results.delete();
        pos = find_pending(k);
        if (f == FUNC_ADD)
        begin
            if (pos < q_count)
            begin
                return;
            end
            if (q_count > 0 && x < q_index[q_head])
            begin
                word_results.insert(word_results.size(), '{k, x, p, STATUS_BACKWARD, 1'b1});
                return;
            end
            if (q_count >= DEPTH)
            begin
                word_results.insert(word_results.size(), '{k, x, p, STATUS_FULL, 1'b1});
                return;
            end
            s = (q_head + q_count) % DEPTH;
            q_key[s] = k;
            q_index[s] = x;
            q_requester[s] = p;
            q_mask[s] = '0;
            q_count++;
            return;
        end
        if (pos >= q_count)
        begin
            return;
        end
        s = (q_head + pos) % DEPTH;
        q_mask[s][p] = 1'b1;
        if ($countones(q_mask[s]) + 1 < int'(quorum))
        begin
            return;
        end
        cut_index = q_index[s];
        for (int i = 0; i <= pos; i++)
        begin
            h = q_head;
            q_head = (q_head + 1) % DEPTH;
            q_count--;
            if (q_index[h] > cut_index)
            begin
                word_results.insert(word_results.size(),
                                    '{q_key[h], cut_index, q_requester[h],
                                      STATUS_UNEXPECTED, 1'b1});
                return;
            end
            word_results.insert(word_results.size(),
                                '{q_key[h], cut_index, q_requester[h], STATUS_RELEASED,
                                  logic'(i == pos)});
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 25);
    endfunction

    task automatic send_word(func_t f, logic [KEY_W-1:0] k, logic [IDX_W-1:0] x,
                             logic [PEER_W-1:0] p, bit gapless);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{PAD_W{1'b0}}, p, x, k};
        s_axis_tuser <= f;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_quorum(logic [QS_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        quorum = value;
    endtask

    task automatic random_phase(int n, bit gapless);
        func_t             f;
        logic [KEY_W-1:0]  k;
        logic [IDX_W-1:0]  x;
        logic [IDX_W-1:0]  base;
        logic [PEER_W-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            k = {$urandom, $urandom};
            x = {$urandom, $urandom};
            p = $urandom_range(0, 7);
            if (q_count == 0 || $urandom_range(0, 1) == 0)
            begin
                f = FUNC_ADD;
                base = (q_count > 0) ? q_index[q_head] : {$urandom, $urandom};
                case ($urandom_range(0, 19))
                    0: ;
                    1: x = base - $urandom_range(1, 5);
                    2:
                    begin
                        x = base + $urandom_range(0, 40);
                        if (q_count > 0)
                        begin
                            k = q_key[(q_head + $urandom_range(0, q_count - 1)) % DEPTH];
                        end
                    end
                    default: x = base + $urandom_range(0, 40);
                endcase
            end
            else
            begin
                f = FUNC_CONFIRM;
                if ($urandom_range(0, 9) != 0)
                begin
                    // Keep confirming one key with rotating peers so that high quorums are met.
                    if (find_pending(focus_key) == q_count || $urandom_range(0, 9) < 3)
                    begin
                        focus_key = q_key[(q_head + $urandom_range(0, q_count - 1)) % DEPTH];
                    end
                    k = focus_key;
                    p = peer_turn;
                    peer_turn++;
                end
            end
            send_word(f, k, x, p, gapless);
            predict_tracker(f, k, x, p);
            foreach (word_results[j])
            begin
                awaited_results.insert(awaited_results.size(), word_results[j]);
            end
        end
    endtask

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        read_result_t got;
        read_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.key = m_axis_tdata[KEY_W-1:0];
            got.index = m_axis_tdata[KEY_W+IDX_W-1:KEY_W];
            got.requester = m_axis_tdata[PAYLOAD_W-1:KEY_W+IDX_W];
            got.status = status_t'(m_axis_tuser);
            got.last = m_axis_tlast;
            words_taken++;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %p", $time, got);
            end
            else
            begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (got.key !== want.key)
                begin
                    report_mismatch("out_key", want.key, got.key);
                end
                if (got.index !== want.index)
                begin
                    report_mismatch("out_index", want.index, got.index);
                end
                if (got.requester !== want.requester)
                begin
                    report_mismatch("out_requester", want.requester, got.requester);
                end
                if (got.status !== want.status)
                begin
                    report_mismatch("status", want.status, got.status);
                end
                if (got.last !== want.last)
                begin
                    report_mismatch("tlast", want.last, got.last);
                end
            end
        end
    end

    // The receiver stalls at random and once holds off long enough to back up the input.
    initial
    begin
        bit long_hold_done;
        bit ready;
        int run;
        long_hold_done = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && words_taken >= 30)
            begin
                long_hold_done = 1'b1;
                ready = 1'b0;
                run = 150;
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                ready = 1'b1;
                run = $urandom_range(1, 20);
            end
            else
            begin
                ready = 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            m_axis_tready <= ready;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] k;
        logic [IDX_W-1:0] x;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        q_head = 0;
        q_count = 0;
        quorum = QS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (request_rows[r])
        begin
            for (int i = 0; i < request_rows[r].repeats; i++)
            begin
                k = request_rows[r].key + i;
                x = request_rows[r].index + i;
                send_word(request_rows[r].func, k, x, request_rows[r].peer, 1'b0);
                predict_tracker(request_rows[r].func, k, x, request_rows[r].peer);
                case (request_rows[r].kind)
                    ROW_ECHO:
                    begin
                        awaited_results.insert(awaited_results.size(),
                                               '{k, x, request_rows[r].peer,
                                                 request_rows[r].status, 1'b1});
                    end
                    ROW_PREDICT:
                    begin
                        foreach (word_results[j])
                        begin
                            awaited_results.insert(awaited_results.size(), word_results[j]);
                        end
                    end
                    default: ;
                endcase
            end
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            drain_results();
            write_quorum(ph == 6 ? QS_W'($urandom_range(1, 8)) : phase_quorum[ph]);
            random_phase(phase_items[ph], ph % 3 == 1);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rqt_pkg.sv
hw/rtl/rqt_cell.sv
hw/rtl/read_index_quorum_tracker_core.sv
verif/tb_top.sv
